FILE: design/ccol_pkg.sv
// Package for the coulomb counter with overcurrent levels.
// Holds widths, reset values, register and level codes, item and ALU structs.
// No dependencies; every other design file imports it.
package ccol_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CHARGE_BITS = 40;

  localparam int GAIN_W    = 20;
  localparam int GAIN_FRAC = 16;
  localparam int FLOOR_W   = 12;
  localparam int MA_W      = 16;
  localparam int EL_W      = 16;
  localparam int PCT_W     = 8;
  localparam int LVL_W     = 3;
  localparam int SOC_W     = 14;
  localparam int REM_W     = 40;
  localparam int CAP_W     = 40;

  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 3;

  localparam int CMP_W     = (SAMPLE_BITS > FLOOR_W) ? SAMPLE_BITS : FLOOR_W;
  localparam int MUL_A_W   = (SAMPLE_BITS > MA_W) ? SAMPLE_BITS : MA_W;
  localparam int MUL_B_W   = GAIN_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int CHUNK_W   = MUL_B_W;
  localparam int CHUNKS    = (CHARGE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W     = CHUNKS * CHUNK_W;
  localparam int NUM_W     = CHARGE_BITS + SOC_W;
  localparam int ALU_W     = NUM_W + 1;
  localparam int QUO_W     = MA_W + 7;
  localparam int CNT_W     = $clog2(QUO_W + 1);

  localparam int PCT_SCALE = 100;
  localparam int SOC_SCALE = 10000;
  localparam int PCT_MAX   = 255;
  localparam int SOC_MAX   = 10000;

  localparam logic [GAIN_W-1:0]      GAIN_RST     = GAIN_W'(498202);
  localparam logic [FLOOR_W-1:0]     FLOOR_RST    = FLOOR_W'(19);
  localparam logic [MA_W-1:0]        CAUTION_RST  = MA_W'(5000);
  localparam logic [MA_W-1:0]        WARNING_RST  = MA_W'(8000);
  localparam logic [MA_W-1:0]        CRITICAL_RST = MA_W'(12000);
  localparam logic [MA_W-1:0]        EXTREME_RST  = MA_W'(15000);
  localparam logic [MA_W-1:0]        FUSE_RST     = MA_W'(18000);
  localparam logic [CHARGE_BITS-1:0] CAP_RST      = CHARGE_BITS'(64'd32400000000);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN     = 3'd0,
    REG_FLOOR    = 3'd1,
    REG_CAUTION  = 3'd2,
    REG_WARNING  = 3'd3,
    REG_CRITICAL = 3'd4,
    REG_EXTREME  = 3'd5,
    REG_FUSE     = 3'd6,
    REG_CAPACITY = 3'd7
  } reg_idx_t;

  typedef enum logic [LVL_W-1:0] {
    LVL_NORMAL   = 3'd0,
    LVL_CAUTION  = 3'd1,
    LVL_WARNING  = 3'd2,
    LVL_CRITICAL = 3'd3,
    LVL_EXTREME  = 3'd4,
    LVL_FUSE     = 3'd5
  } level_t;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_raw;
    logic [EL_W-1:0]        elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [MA_W-1:0]  current_ma;
    logic [PCT_W-1:0] fuse_load_percent;
    logic [LVL_W-1:0] load_level;
    logic             shutdown;
    logic [REM_W-1:0] remaining_mams;
    logic [SOC_W-1:0] charge_state;
  } out_item_t;

  typedef struct packed {
    alu_op_t            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
    logic [MUL_A_W-1:0] ma;
    logic [MUL_B_W-1:0] mb;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]   sum;
    logic [MUL_P_W-1:0] prod;
  } alu_rsp_t;

endpackage

FILE: design/ccol_alu.sv
// Shared arithmetic unit: one multiplier and one wide adder/subtractor.
// Driven each cycle by the sequencer in the top level; uses ccol_pkg.
module ccol_alu (
  input  ccol_pkg::alu_req_t req,
  output ccol_pkg::alu_rsp_t rsp
);
  import ccol_pkg::*;

  always_comb begin
    rsp.prod = MUL_P_W'(req.ma) * MUL_P_W'(req.mb);
    unique case (req.op)
      ALU_SUB: rsp.sum = req.a - req.b;
      default: rsp.sum = req.a + req.b;
    endcase
  end

endmodule

FILE: design/coulomb_counter_with_overcurrent_levels_top.sv
// Top level of the coulomb counter with overcurrent levels.
// Holds the register file, the sequencer and the result register; uses ccol_pkg
// and the shared arithmetic unit ccol_alu.
//
// Usage:
// Each input item carries one current-sense sample and the milliseconds since
// the previous one; each accepted item yields exactly one result item with the
// current, fuse load, load level, shutdown flag, remaining charge and state of
// charge. Both channels use valid/ready.
// Registers are written over the APB-style port at byte address 8*i, with
// 64-bit data; writing the capacity register also refills the remaining charge.
// Write registers only while the block is idle.
// Timing: the block works on one item at a time. A new item is accepted only
// once the previous result has been loaded into the output register. The
// shared subtractor runs 23 steps of the fuse-load division and 14 steps of
// the state-of-charge division, plus the chunked charge scaling.
// Reset loads every register with its default and sets the remaining charge
// to the default capacity. A stalled receiver holds the result in the output
// register; the next item can still be accepted and worked on, and it waits
// at its end until the register frees up.
module coulomb_counter_with_overcurrent_levels_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  ccol_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output ccol_pkg::out_item_t                    out_data,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ccol_pkg::ADDR_W-1:0]            paddr,
  input  logic [ccol_pkg::DATA_W-1:0]            pwdata,
  output logic [ccol_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);
  import ccol_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_MA       = 9'b000000010,
    S_PCT_MUL  = 9'b000000100,
    S_PCT_DIV  = 9'b000001000,
    S_USED     = 9'b000010000,
    S_SUB      = 9'b000100000,
    S_SOC_MUL  = 9'b001000000,
    S_SOC_DIV  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]      gain_r, gain_nxt;
  logic [FLOOR_W-1:0]     floor_r, floor_nxt;
  logic [MA_W-1:0]        caution_r, caution_nxt;
  logic [MA_W-1:0]        warning_r, warning_nxt;
  logic [MA_W-1:0]        critical_r, critical_nxt;
  logic [MA_W-1:0]        extreme_r, extreme_nxt;
  logic [MA_W-1:0]        fuse_r, fuse_nxt;
  logic [CHARGE_BITS-1:0] capacity_r, capacity_nxt;
  logic [CHARGE_BITS-1:0] remaining_r, remaining_nxt;

  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [EL_W-1:0]        elapsed_r, elapsed_nxt;
  logic [MA_W-1:0]        ma_r, ma_nxt;
  logic [MA_W+EL_W-1:0]   used_r, used_nxt;
  logic [PCT_W-1:0]       pct_r, pct_nxt;
  logic [MUL_P_W-1:0]     prod_r, prod_nxt;
  logic [NUM_W-1:0]       acc_r, acc_nxt;
  logic [PAD_W-1:0]       chunk_r, chunk_nxt;
  logic [CHARGE_BITS:0]   div_rem_r, div_rem_nxt;
  logic [NUM_W-1:0]       div_num_r, div_num_nxt;
  logic [CHARGE_BITS-1:0] div_den_r, div_den_nxt;
  logic [QUO_W-1:0]       div_quo_r, div_quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  logic                   cfg_wr;
  reg_idx_t               reg_idx;
  logic [CHARGE_BITS:0]   rem_sh;
  logic                   div_fits;
  logic [CHARGE_BITS:0]   rem_step;
  logic [QUO_W-1:0]       quo_step;
  logic [NUM_W-1:0]       acc_sum;
  logic [CHARGE_BITS-1:0] rem_new;
  logic                   out_load;
  level_t                 level;
  out_item_t              result;

  ccol_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign reg_idx  = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    unique case (reg_idx)
      REG_GAIN:     prdata = DATA_W'(gain_r);
      REG_FLOOR:    prdata = DATA_W'(floor_r);
      REG_CAUTION:  prdata = DATA_W'(caution_r);
      REG_WARNING:  prdata = DATA_W'(warning_r);
      REG_CRITICAL: prdata = DATA_W'(critical_r);
      REG_EXTREME:  prdata = DATA_W'(extreme_r);
      REG_FUSE:     prdata = DATA_W'(fuse_r);
      REG_CAPACITY: prdata = DATA_W'(capacity_r);
      default:      prdata = '0;
    endcase
  end

  // Restoring divider step shared by both divisions.
  assign rem_sh   = {div_rem_r[CHARGE_BITS-1:0], div_num_r[NUM_W-1]};
  assign div_fits = ~alu_rsp.sum[ALU_W-1];
  assign rem_step = div_fits ? alu_rsp.sum[CHARGE_BITS:0] : rem_sh;
  assign quo_step = {div_quo_r[QUO_W-2:0], div_fits};
  assign acc_sum  = alu_rsp.sum[NUM_W-1:0];

  // Levels are tested from the top down with a strict compare.
  always_comb begin
    if (ma_r > fuse_r)          level = LVL_FUSE;
    else if (ma_r > extreme_r)  level = LVL_EXTREME;
    else if (ma_r > critical_r) level = LVL_CRITICAL;
    else if (ma_r > warning_r)  level = LVL_WARNING;
    else if (ma_r > caution_r)  level = LVL_CAUTION;
    else                        level = LVL_NORMAL;
  end

  always_comb begin
    result.current_ma        = ma_r;
    result.fuse_load_percent = (fuse_r == '0) ? PCT_W'(PCT_MAX) : pct_r;
    result.load_level        = level;
    result.shutdown          = (level == LVL_EXTREME) || (level == LVL_FUSE);
    result.remaining_mams    = REM_W'(remaining_r);
    if (capacity_r == '0 || div_quo_r > QUO_W'(SOC_MAX)) begin
      result.charge_state = SOC_W'(SOC_MAX);
    end else begin
      result.charge_state = div_quo_r[SOC_W-1:0];
    end
  end

  // Operands of the shared unit depend only on the state and the registers.
  always_comb begin
    alu_req    = '0;
    alu_req.op = ALU_ADD;
    unique case (state_r)
      S_MA: begin
        alu_req.ma = MUL_A_W'(sample_r);
        alu_req.mb = gain_r;
      end
      S_PCT_MUL: begin
        alu_req.ma = MUL_A_W'(ma_r);
        alu_req.mb = MUL_B_W'(PCT_SCALE);
      end
      S_PCT_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(rem_sh);
        alu_req.b  = ALU_W'(div_den_r);
      end
      S_USED: begin
        alu_req.ma = MUL_A_W'(ma_r);
        alu_req.mb = MUL_B_W'(elapsed_r);
      end
      S_SUB: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(remaining_r);
        alu_req.b  = ALU_W'(used_r);
      end
      S_SOC_MUL: begin
        // Remaining charge times the scale, one chunk per cycle from the top,
        // with the product registered before it is accumulated.
        alu_req.ma = MUL_A_W'(SOC_SCALE);
        alu_req.mb = chunk_r[PAD_W-1 -: CHUNK_W];
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'({acc_r[NUM_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}});
        alu_req.b  = ALU_W'(prod_r);
      end
      S_SOC_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(rem_sh);
        alu_req.b  = ALU_W'(div_den_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    gain_nxt      = gain_r;
    floor_nxt     = floor_r;
    caution_nxt   = caution_r;
    warning_nxt   = warning_r;
    critical_nxt  = critical_r;
    extreme_nxt   = extreme_r;
    fuse_nxt      = fuse_r;
    capacity_nxt  = capacity_r;
    remaining_nxt = remaining_r;
    sample_nxt    = sample_r;
    elapsed_nxt   = elapsed_r;
    ma_nxt        = ma_r;
    used_nxt      = used_r;
    pct_nxt       = pct_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    chunk_nxt     = chunk_r;
    div_rem_nxt   = div_rem_r;
    div_num_nxt   = div_num_r;
    div_den_nxt   = div_den_r;
    div_quo_nxt   = div_quo_r;
    cnt_nxt       = cnt_r;
    out_load      = 1'b0;
    rem_new       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt  = in_data.sample_raw;
          elapsed_nxt = in_data.elapsed_ms;
          state_nxt   = S_MA;
        end
      end
      S_MA: begin
        if (CMP_W'(sample_r) < CMP_W'(floor_r)) begin
          ma_nxt = '0;
        end else if (alu_rsp.prod[MUL_P_W-1:GAIN_FRAC+MA_W] != '0) begin
          ma_nxt = '1;
        end else begin
          ma_nxt = alu_rsp.prod[GAIN_FRAC+MA_W-1:GAIN_FRAC];
        end
        state_nxt = S_PCT_MUL;
      end
      S_PCT_MUL: begin
        div_num_nxt = {alu_rsp.prod[QUO_W-1:0], {(NUM_W-QUO_W){1'b0}}};
        div_rem_nxt = '0;
        div_den_nxt = CHARGE_BITS'(fuse_r);
        div_quo_nxt = '0;
        cnt_nxt     = CNT_W'(QUO_W - 1);
        state_nxt   = S_PCT_DIV;
      end
      S_PCT_DIV: begin
        div_rem_nxt = rem_step;
        div_num_nxt = div_num_r << 1;
        div_quo_nxt = quo_step;
        if (cnt_r == '0) begin
          pct_nxt   = (quo_step > QUO_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : quo_step[PCT_W-1:0];
          state_nxt = S_USED;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_USED: begin
        used_nxt   = alu_rsp.prod[MA_W+EL_W-1:0];
        state_nxt  = S_SUB;
      end
      S_SUB: begin
        // The charge floors at zero once the used charge reaches what is left.
        if (!alu_rsp.sum[ALU_W-1] && alu_rsp.sum != '0) begin
          rem_new = alu_rsp.sum[CHARGE_BITS-1:0];
        end
        remaining_nxt = rem_new;
        chunk_nxt     = PAD_W'(rem_new);
        acc_nxt       = '0;
        cnt_nxt       = CNT_W'(CHUNKS);
        state_nxt     = S_SOC_MUL;
      end
      S_SOC_MUL: begin
        prod_nxt   = alu_rsp.prod;
        chunk_nxt  = chunk_r << CHUNK_W;
        if (cnt_r != CNT_W'(CHUNKS)) begin
          acc_nxt = acc_sum;
        end
        if (cnt_r == '0) begin
          div_rem_nxt = {1'b0, acc_sum[NUM_W-1:SOC_W]};
          div_num_nxt = {acc_sum[SOC_W-1:0], {(NUM_W-SOC_W){1'b0}}};
          div_den_nxt = capacity_r;
          div_quo_nxt = '0;
          cnt_nxt     = CNT_W'(SOC_W - 1);
          state_nxt   = S_SOC_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_SOC_DIV: begin
        div_rem_nxt = rem_step;
        div_num_nxt = div_num_r << 1;
        div_quo_nxt = quo_step;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN:     gain_nxt     = pwdata[GAIN_W-1:0];
        REG_FLOOR:    floor_nxt    = pwdata[FLOOR_W-1:0];
        REG_CAUTION:  caution_nxt  = pwdata[MA_W-1:0];
        REG_WARNING:  warning_nxt  = pwdata[MA_W-1:0];
        REG_CRITICAL: critical_nxt = pwdata[MA_W-1:0];
        REG_EXTREME:  extreme_nxt  = pwdata[MA_W-1:0];
        REG_FUSE:     fuse_nxt     = pwdata[MA_W-1:0];
        REG_CAPACITY: begin
          capacity_nxt  = CHARGE_BITS'(pwdata[CAP_W-1:0]);
          remaining_nxt = CHARGE_BITS'(pwdata[CAP_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);
  assign out_data_nxt  = out_load ? result : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      gain_r      <= GAIN_RST;
      floor_r     <= FLOOR_RST;
      caution_r   <= CAUTION_RST;
      warning_r   <= WARNING_RST;
      critical_r  <= CRITICAL_RST;
      extreme_r   <= EXTREME_RST;
      fuse_r      <= FUSE_RST;
      capacity_r  <= CAP_RST;
      remaining_r <= CAP_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      gain_r      <= gain_nxt;
      floor_r     <= floor_nxt;
      caution_r   <= caution_nxt;
      warning_r   <= warning_nxt;
      critical_r  <= critical_nxt;
      extreme_r   <= extreme_nxt;
      fuse_r      <= fuse_nxt;
      capacity_r  <= capacity_nxt;
      remaining_r <= remaining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    elapsed_r  <= elapsed_nxt;
    ma_r       <= ma_nxt;
    used_r     <= used_nxt;
    pct_r      <= pct_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    chunk_r    <= chunk_nxt;
    div_rem_r  <= div_rem_nxt;
    div_num_r  <= div_num_nxt;
    div_den_r  <= div_den_nxt;
    div_quo_r  <= div_quo_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_rem_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    remaining_r <= capacity_r)
    else $error("remaining charge exceeds capacity");

  a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.charge_state <= SOC_W'(SOC_MAX))
    else $error("state of charge above full scale");

  a_shutdown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.shutdown ==
      ((out_data_r.load_level == LVL_EXTREME) || (out_data_r.load_level == LVL_FUSE)))
    else $error("shutdown does not match load level");

  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.current_ma == '0) |-> out_data_r.load_level == LVL_NORMAL)
    else $error("zero current graded above normal");
`endif

endmodule
